### sv/partition_fit_allocator_unit_assert.svh
// Assertion macros used by the partition allocator RTL.
`ifndef PARTITION_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// Clocked property check, disabled while reset is asserted.
`define PFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define PFA_ASSERT_NEVER(lbl, cond, msg) \
  `PFA_ASSERT(lbl, !(cond), msg)

`endif

### sv/pfa_pkg.sv
// Shared types and constants of the partition allocator.
`default_nettype none

package pfa_pkg;

  // Width of a partition size and of a requested amount.
  localparam int AMT_W = 16;

  // Width of the placement rule register.
  localparam int POL_W = 2;

  // Request operation codes.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  // Placement rules; the unused code behaves as first fit.
  typedef enum logic [POL_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_policy_e;

  // Response status codes.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SPLIT,
    S_REPLY
  } state_e;

endpackage

`default_nettype wire

### sv/pfa_cfg_if.sv
// Configuration write channel carrying the placement rule.
`default_nettype none

interface pfa_cfg_if import pfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POL_W-1:0] fit_policy;

  modport source (output valid, output fit_policy, input ready);
  modport sink (input valid, input fit_policy, output ready);
endinterface

`default_nettype wire

### sv/pfa_req_if.sv
// Request channel: load a hole or allocate a block.
`default_nettype none

interface pfa_req_if import pfa_pkg::*; #(
  parameter int ADDR_W  = 16,
  parameter int OWNER_W = 8
) ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [OWNER_W-1:0] owner_id;
  logic [ADDR_W-1:0]  hole_base;
  logic [AMT_W-1:0]   amount;

  modport source (output valid, output op, output owner_id, output hole_base,
                  output amount, input ready);
  modport sink (input valid, input op, input owner_id, input hole_base,
                input amount, output ready);
endinterface

`default_nettype wire

### sv/pfa_rsp_if.sv
// Response channel: status and granted base address.
`default_nettype none

interface pfa_rsp_if #(
  parameter int ADDR_W = 16
) ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] granted_base;

  modport source (output valid, output status, output granted_base, input ready);
  modport sink (input valid, input status, input granted_base, output ready);
endinterface

`default_nettype wire

### sv/partition_fit_allocator_unit.sv
// Partition table allocator with first, best and worst fit placement.
// A load, or an allocation with a zero amount or an empty table, passes from idle to the reply
// state, and the next request is accepted once the reply state has moved the result out.
// An allocation scans the n partitions in use, one per cycle, then passes the decide state
// (and the split state on a split) and the reply state; a held response stalls it.
// Reset (async, active low) empties the table and selects first fit.
`default_nettype none

`include "partition_fit_allocator_unit_assert.svh"

module partition_fit_allocator_unit import pfa_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int ADDR_W  = 16,
  parameter int OWNER_W = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfa_cfg_if.sink    cfg_i,
  pfa_req_if.sink    req_i,
  pfa_rsp_if.source  rsp_o
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int FW    = $clog2(ENTRIES + 1);
  localparam int SUM_W = (ADDR_W > AMT_W) ? ADDR_W : AMT_W;
  localparam logic [FW-1:0] FULL_CNT = FW'(ENTRIES);

  typedef struct packed {
    logic               taken;
    logic [OWNER_W-1:0] owner;
    logic [AMT_W-1:0]   size;
    logic [ADDR_W-1:0]  base;
  } slot_t;

  // Partition table memory and its ports.
  slot_t          mem_q [ENTRIES];
  logic           mem_we;
  logic [IW-1:0]  mem_wa;
  slot_t          mem_wd;
  logic           mem_re;
  logic [IW-1:0]  mem_ra;
  slot_t          rd_data_q;

  // Control state.
  state_e         state_q, state_d;
  logic [POL_W-1:0] policy_q;
  logic [FW-1:0]  fill_q, fill_d;
  logic [FW-1:0]  scan_q, scan_d;
  logic           rd_vld_q, rd_vld_d;
  logic           best_vld_q, best_vld_d;
  logic           rsp_valid_q, rsp_valid_d;

  // Datapath registers.
  logic [IW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [IW-1:0]      best_idx_q, best_idx_d;
  logic [AMT_W-1:0]   best_size_q, best_size_d;
  logic [ADDR_W-1:0]  best_base_q, best_base_d;
  logic [OWNER_W-1:0] owner_q, owner_d;
  logic [AMT_W-1:0]   amt_q, amt_d;
  status_e            pend_status_q, pend_status_d;
  logic [ADDR_W-1:0]  pend_base_q, pend_base_d;
  status_e            rsp_status_q, rsp_status_d;
  logic [ADDR_W-1:0]  rsp_base_q, rsp_base_d;

  logic               req_fire;
  logic               out_free;
  logic               cand;
  logic               better;
  logic [SUM_W-1:0]   hole_sum;

  // Synchronous table memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  assign cfg_i.ready  = 1'b1;
  assign req_i.ready  = (state_q == S_IDLE);
  assign req_fire     = req_i.valid && req_i.ready;
  assign out_free     = !rsp_valid_q || rsp_o.ready;

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.granted_base = rsp_base_q;

  // The entry just read is a candidate when it is free and large enough.
  assign cand = rd_vld_q && !rd_data_q.taken && (rd_data_q.size >= amt_q);

  // Placement rule: does the entry just read beat the current choice?
  always_comb begin
    if (!best_vld_q) begin
      better = 1'b1;
    end else begin
      unique case (policy_q)
        FIT_BEST: begin
          if (rd_data_q.size != best_size_q) begin
            better = rd_data_q.size < best_size_q;
          end else begin
            better = rd_data_q.base < best_base_q;
          end
        end
        FIT_WORST: begin
          if (rd_data_q.size != best_size_q) begin
            better = rd_data_q.size > best_size_q;
          end else begin
            better = rd_data_q.base > best_base_q;
          end
        end
        default: begin
          better = rd_data_q.base < best_base_q;
        end
      endcase
    end
  end

  // Base of the leftover hole wraps at the top of the address range.
  assign hole_sum = SUM_W'(best_base_q) + SUM_W'(amt_q);

  // Sequencer: next state, memory accesses and result staging.
  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    scan_d        = scan_q;
    rd_vld_d      = 1'b0;
    best_vld_d    = best_vld_q;
    cmp_idx_d     = cmp_idx_q;
    best_idx_d    = best_idx_q;
    best_size_d   = best_size_q;
    best_base_d   = best_base_q;
    owner_d       = owner_q;
    amt_d         = amt_q;
    pend_status_d = pend_status_q;
    pend_base_d   = pend_base_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    rsp_status_d  = rsp_status_q;
    rsp_base_d    = rsp_base_q;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          owner_d     = OWNER_W'(req_i.owner_id);
          amt_d       = req_i.amount;
          pend_base_d = '0;
          state_d     = S_REPLY;
          if (req_i.op == OP_LOAD) begin
            // A load with a nonzero amount writes a free hole into the next unused slot, if there is one.
            pend_status_d = STAT_DONE;
            if (req_i.amount != '0) begin
              if (fill_q == FULL_CNT) begin
                pend_status_d = STAT_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_wa       = fill_q[IW-1:0];
                mem_wd.taken = 1'b0;
                mem_wd.owner = '0;
                mem_wd.size  = req_i.amount;
                mem_wd.base  = ADDR_W'(req_i.hole_base);
                fill_d       = fill_q + FW'(1);
              end
            end
          end else if ((req_i.amount == '0) || (fill_q == '0)) begin
            pend_status_d = STAT_NOFIT;
          end else begin
            // Start the table scan at entry zero.
            mem_re     = 1'b1;
            mem_ra     = '0;
            rd_vld_d   = 1'b1;
            cmp_idx_d  = '0;
            scan_d     = FW'(1);
            best_vld_d = 1'b0;
            state_d    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while comparing the entry read last cycle.
        if (scan_q < fill_q) begin
          mem_re    = 1'b1;
          mem_ra    = scan_q[IW-1:0];
          rd_vld_d  = 1'b1;
          cmp_idx_d = scan_q[IW-1:0];
          scan_d    = scan_q + FW'(1);
        end
        if (cand && better) begin
          best_vld_d  = 1'b1;
          best_idx_d  = cmp_idx_q;
          best_size_d = rd_data_q.size;
          best_base_d = rd_data_q.base;
        end
        if (rd_vld_q && (FW'(cmp_idx_q) == (fill_q - FW'(1)))) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_d     = S_REPLY;
        pend_base_d = '0;
        if (!best_vld_q) begin
          pend_status_d = STAT_NOFIT;
        end else if (best_size_q == amt_q) begin
          // Exact fit: mark the partition taken, no hole is left.
          mem_we        = 1'b1;
          mem_wa        = best_idx_q;
          mem_wd.taken  = 1'b1;
          mem_wd.owner  = owner_q;
          mem_wd.size   = best_size_q;
          mem_wd.base   = best_base_q;
          pend_status_d = STAT_DONE;
          pend_base_d   = best_base_q;
        end else if (fill_q == FULL_CNT) begin
          pend_status_d = STAT_FULL;
        end else begin
          // Split: the remainder becomes a new hole first.
          mem_we       = 1'b1;
          mem_wa       = fill_q[IW-1:0];
          mem_wd.taken = 1'b0;
          mem_wd.owner = '0;
          mem_wd.size  = best_size_q - amt_q;
          mem_wd.base  = hole_sum[ADDR_W-1:0];
          fill_d       = fill_q + FW'(1);
          state_d      = S_SPLIT;
        end
      end

      S_SPLIT: begin
        // Shrink the chosen partition to the granted front part.
        mem_we        = 1'b1;
        mem_wa        = best_idx_q;
        mem_wd.taken  = 1'b1;
        mem_wd.owner  = owner_q;
        mem_wd.size   = amt_q;
        mem_wd.base   = best_base_q;
        pend_status_d = STAT_DONE;
        pend_base_d   = best_base_q;
        state_d       = S_REPLY;
      end

      S_REPLY: begin
        // Move the result into the output register once it is free.
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = pend_status_q;
          rsp_base_d   = pend_base_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= FIT_FIRST;
      fill_q      <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      best_vld_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      best_vld_q  <= best_vld_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        policy_q <= cfg_i.fit_policy;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q     <= cmp_idx_d;
    best_idx_q    <= best_idx_d;
    best_size_q   <= best_size_d;
    best_base_q   <= best_base_d;
    owner_q       <= owner_d;
    amt_q         <= amt_d;
    pend_status_q <= pend_status_d;
    pend_base_q   <= pend_base_d;
    rsp_status_q  <= rsp_status_d;
    rsp_base_q    <= rsp_base_d;
  end

  // The fill count never passes the table depth.
  `PFA_ASSERT(a_fill_bound, fill_q <= FULL_CNT, "fill count beyond table depth")
  // The fill count only grows, one slot at a time.
  `PFA_ASSERT(a_fill_step, fill_q != $past(fill_q) |-> fill_q == $past(fill_q) + FW'(1),
              "fill count moved by other than one")
  // No table write while a scan reads it.
  `PFA_ASSERT_NEVER(a_no_write_in_scan, (state_q == S_SCAN) && mem_we,
                    "table written during scan")
  // A failed request reports a zero base.
  `PFA_ASSERT(a_fail_zero_base, rsp_valid_q && (rsp_status_q != STAT_DONE) |-> rsp_base_q == '0,
              "nonzero base on a failed request")
  // A new response is only loaded from the reply state.
  `PFA_ASSERT(a_rsp_from_reply, $rose(rsp_valid_q) |-> $past(state_q) == S_REPLY,
              "response raised outside reply state")

endmodule

`default_nettype wire

### bench/partition_fit_allocator_unit_tb.sv
// Self-checking testbench for the partition fit allocator: directed table plus random traffic.
`timescale 1ns / 1ps

module partition_fit_allocator_unit_tb import pfa_pkg::*; ();

  localparam int SLOTS = 16;
  localparam int ADDR_W = 16;
  localparam int OWNER_W = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 200;

  // Spare placement code; the block treats it as first fit.
  localparam logic [POL_W-1:0] FIT_SPARE = 2'd3;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  // One line of the directed plan: a request, or a placement rule write.
  typedef struct {
    row_kind_e        kind;
    op_e              op;
    logic [POL_W-1:0] rule;
    logic [7:0]       owner;
    logic [15:0]      base;
    logic [15:0]      amount;
    logic             typed;
    status_e          want_st;
    logic [15:0]      want_base;
  } row_t;

  typedef struct {
    status_e           st;
    logic [ADDR_W-1:0] base;
  } grant_t;

  logic clk_i;
  logic rst_ni;

  pfa_cfg_if cfg_bus ();
  pfa_req_if #(.ADDR_W(ADDR_W), .OWNER_W(OWNER_W)) req_bus ();
  pfa_rsp_if #(.ADDR_W(ADDR_W)) rsp_bus ();

  partition_fit_allocator_unit #(
    .ENTRIES(SLOTS),
    .ADDR_W (ADDR_W),
    .OWNER_W(OWNER_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Mirror of the partition table and the placement rule.
  logic                 part_used  [SLOTS];
  logic                 part_taken [SLOTS];
  logic [ADDR_W-1:0]    part_base  [SLOTS];
  logic [AMT_W-1:0]     part_size  [SLOTS];
  logic [OWNER_W-1:0]   part_owner [SLOTS];
  logic [POL_W-1:0]     fit_rule;

  grant_t pending_grants[$];

  int  errors;
  int  load_reqs;
  int  alloc_reqs;
  int  done_seen;
  int  nofit_seen;
  int  full_seen;
  int  rules_written;
  bit  calm;
  int  stall_epoch;

  // Directed plan: empty table, zero sizes, wrap, exact fit, ties, full table.
  row_t plan [28] = '{
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'h00, 16'h0000, 16'h0001, 1'b1, STAT_NOFIT, 16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, STAT_NOFIT, 16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h1234, 16'h0000, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'hFFF0, 16'h0020, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h1000, 16'h0100, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h1080, 16'h0100, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h4000, 16'hFFFF, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h2000, 16'h0100, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'hFF, 16'h0000, 16'h0010, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_CFG, OP_LOAD,  FIT_WORST, 8'h00, 16'h0000, 16'h0000, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'h00, 16'h0000, 16'h0020, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_CFG, OP_LOAD,  FIT_BEST,  8'h00, 16'h0000, 16'h0000, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'h5A, 16'hFFFF, 16'h0018, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'hA5, 16'h0000, 16'h0008, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'h3C, 16'h0000, 16'h0100, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h3000, 16'h0040, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h3000, 16'h0040, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'hC3, 16'h0000, 16'h0040, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_CFG, OP_LOAD,  FIT_SPARE, 8'h00, 16'h0000, 16'h0000, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'h01, 16'h0000, 16'h0001, 1'b0, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h0000, 16'h0001, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h5555, 16'hAAAA, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'hAAAA, 16'h5555, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h8000, 16'h0002, 1'b1, STAT_DONE,  16'h0000},
    '{ROW_REQ, OP_LOAD,  FIT_FIRST, 8'h00, 16'h0100, 16'h0010, 1'b1, STAT_FULL,  16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'h7E, 16'h0000, 16'h0002, 1'b1, STAT_FULL,  16'h0000},
    '{ROW_REQ, OP_ALLOC, FIT_FIRST, 8'h80, 16'h0000, 16'h0001, 1'b1, STAT_DONE,  16'h0000}
  };

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // Computes the response of one request and updates the table mirror.
  function automatic void predict_grant(input op_e op, input logic [OWNER_W-1:0] owner,
                                        input logic [ADDR_W-1:0] base,
                                        input logic [AMT_W-1:0] amount,
                                        output status_e st, output logic [ADDR_W-1:0] granted);
    int   i;
    int   spare;
    int   pick;
    logic wins;
    st = STAT_DONE;
    granted = '0;
    spare = -1;
    pick = -1;
    for (i = SLOTS - 1; i >= 0; i--) begin
      if (!part_used[i]) spare = i;
    end
    if (op == OP_LOAD) begin
      if (amount != '0) begin
        if (spare < 0) begin
          st = STAT_FULL;
        end else begin
          part_used[spare] = 1'b1;
          part_taken[spare] = 1'b0;
          part_base[spare] = base;
          part_size[spare] = amount;
          part_owner[spare] = '0;
        end
      end
    end else if (amount == '0) begin
      st = STAT_NOFIT;
    end else begin
      // Scan in slot order; a later slot only wins on a strictly better key.
      for (i = 0; i < SLOTS; i++) begin
        if (part_used[i] && !part_taken[i] && part_size[i] >= amount) begin
          if (pick < 0) begin
            wins = 1'b1;
          end else begin
            case (fit_rule)
              FIT_BEST: begin
                wins = (part_size[i] != part_size[pick]) ? (part_size[i] < part_size[pick])
                                                         : (part_base[i] < part_base[pick]);
              end
              FIT_WORST: begin
                wins = (part_size[i] != part_size[pick]) ? (part_size[i] > part_size[pick])
                                                         : (part_base[i] > part_base[pick]);
              end
              default: begin
                wins = part_base[i] < part_base[pick];
              end
            endcase
          end
          if (wins) pick = i;
        end
      end
      if (pick < 0) begin
        st = STAT_NOFIT;
      end else if (part_size[pick] == amount) begin
        part_taken[pick] = 1'b1;
        part_owner[pick] = owner;
        granted = part_base[pick];
      end else if (spare < 0) begin
        st = STAT_FULL;
      end else begin
        // The remainder becomes a new hole; its base wraps at the address width.
        part_used[spare] = 1'b1;
        part_taken[spare] = 1'b0;
        part_base[spare] = part_base[pick] + amount;
        part_size[spare] = part_size[pick] - amount;
        part_owner[spare] = '0;
        part_size[pick] = amount;
        part_taken[pick] = 1'b1;
        part_owner[pick] = owner;
        granted = part_base[pick];
      end
    end
  endfunction

  // Offers one request, waits for its acceptance and records the expected response.
  task automatic send_request(input op_e op, input logic [OWNER_W-1:0] owner,
                              input logic [ADDR_W-1:0] base, input logic [AMT_W-1:0] amount,
                              input logic typed, input status_e typed_st,
                              input logic [ADDR_W-1:0] typed_base);
    grant_t guess;
    if (!calm) begin
      while ($urandom_range(99) < 21) begin
        req_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_bus.valid <= 1'b1;
    req_bus.op <= op;
    req_bus.owner_id <= owner;
    req_bus.hole_base <= base;
    req_bus.amount <= amount;
    do @(posedge clk_i); while (!req_bus.ready);
    predict_grant(op, owner, base, amount, guess.st, guess.base);
    if (typed) begin
      guess.st = typed_st;
      guess.base = typed_base;
    end
    pending_grants = {pending_grants, guess};
    if (op == OP_LOAD) load_reqs++;
    else alloc_reqs++;
  endtask

  // Stops offering requests and waits until every response is back.
  task automatic settle_block();
    req_bus.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes the placement rule while the block is idle.
  task automatic write_policy(input logic [POL_W-1:0] rule);
    settle_block();
    cfg_bus.valid <= 1'b1;
    cfg_bus.fit_policy <= rule;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    fit_rule = rule;
    rules_written++;
  endtask

  // One random phase: mostly allocations aimed at the holes that are left.
  task automatic run_random_phase(input logic [POL_W-1:0] rule, input int count);
    int                 n;
    int                 i;
    int                 roll;
    int                 h;
    int                 holes[$];
    op_e                op;
    logic [AMT_W-1:0]   amount;
    write_policy(rule);
    for (n = 0; n < count; n++) begin
      holes.delete();
      for (i = 0; i < SLOTS; i++) begin
        if (part_used[i] && !part_taken[i]) holes = {holes, i};
      end
      op = ($urandom_range(99) < 15) ? OP_LOAD : OP_ALLOC;
      roll = $urandom_range(99);
      amount = AMT_W'($urandom);
      if (roll < 10) begin
        amount = '0;
      end else if (op == OP_ALLOC && holes.size() != 0 && roll < 75) begin
        h = holes[$urandom_range(holes.size() - 1)];
        if (roll < 55) amount = part_size[h];
        else amount = AMT_W'($urandom_range(part_size[h], 1));
      end
      send_request(op, OWNER_W'($urandom), ADDR_W'($urandom), amount, 1'b0, STAT_DONE, '0);
    end
  endtask

  // Response readiness: random stalls, calm stretches, and one long hold-off.
  initial begin
    int seen_epoch;
    int hold_left;
    seen_epoch = 0;
    hold_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_epoch != seen_epoch) begin
        seen_epoch = stall_epoch;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  // Response checker: each response against the oldest expectation.
  always @(posedge clk_i) begin : rsp_check
    grant_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      case (rsp_bus.status)
        STAT_DONE: done_seen++;
        STAT_NOFIT: nofit_seen++;
        default: full_seen++;
      endcase
      if (pending_grants.size() == 0) begin
        flag_error($sformatf("response with none outstanding: status %0d base 0x%04h",
                             rsp_bus.status, rsp_bus.granted_base));
      end else begin
        want = pending_grants.pop_front();
        if (rsp_bus.status !== want.st) begin
          flag_error($sformatf("status: expected %0d, got %0d", want.st, rsp_bus.status));
        end
        if (rsp_bus.granted_base !== want.base) begin
          flag_error($sformatf("granted_base: expected 0x%04h, got 0x%04h",
                               want.base, rsp_bus.granted_base));
        end
      end
    end
  end

  // Watchdog on cycles in which no handshake completes.
  always @(posedge clk_i) begin : watchdog
    int quiet_cycles;
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("partition_fit_allocator_unit regression: fail");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    int r;
    errors = 0;
    load_reqs = 0;
    alloc_reqs = 0;
    done_seen = 0;
    nofit_seen = 0;
    full_seen = 0;
    rules_written = 0;
    calm = 1'b0;
    stall_epoch = 0;
    fit_rule = FIT_FIRST;
    for (r = 0; r < SLOTS; r++) begin
      part_used[r] = 1'b0;
      part_taken[r] = 1'b0;
      part_base[r] = '0;
      part_size[r] = '0;
      part_owner[r] = '0;
    end
    rst_ni <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.fit_policy <= FIT_FIRST;
    req_bus.valid <= 1'b0;
    req_bus.op <= OP_LOAD;
    req_bus.owner_id <= '0;
    req_bus.hole_base <= '0;
    req_bus.amount <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan.
    for (r = 0; r < $size(plan); r++) begin
      if (plan[r].kind == ROW_CFG) begin
        write_policy(plan[r].rule);
      end else begin
        send_request(plan[r].op, plan[r].owner, plan[r].base, plan[r].amount,
                     plan[r].typed, plan[r].want_st, plan[r].want_base);
      end
    end

    // Random phases over every placement rule; one calm, one with a long hold-off.
    run_random_phase(FIT_BEST, PHASE_ITEMS);
    calm = 1'b1;
    run_random_phase(FIT_WORST, PHASE_ITEMS);
    calm = 1'b0;
    write_policy(FIT_SPARE);
    stall_epoch++;
    run_random_phase(FIT_SPARE, PHASE_ITEMS);
    run_random_phase(FIT_FIRST, PHASE_ITEMS);
    run_random_phase(FIT_WORST, PHASE_ITEMS);
    run_random_phase(FIT_BEST, PHASE_ITEMS);
    run_random_phase(FIT_FIRST, PHASE_ITEMS);
    settle_block();

    if (pending_grants.size() != 0) begin
      flag_error($sformatf("%0d responses never arrived", pending_grants.size()));
    end
    $display("Covered %0d loads and %0d allocations over %0d rule writes.",
             load_reqs, alloc_reqs, rules_written);
    $display("Responses: %0d done, %0d no fit, %0d table full; %0d errors.",
             done_seen, nofit_seen, full_seen, errors);
    if (errors == 0) begin
      $display("partition_fit_allocator_unit regression: pass");
    end else begin
      $display("partition_fit_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
